### hdl/deq_pkg.sv
// Shared types and constants for the double-ended queue.
// Holds the command and status codes, the empty-pop marker and the shift strobes.
// No dependencies.
package deq_pkg;

	localparam int DATA_W   = 32;
	localparam int CMD_W    = 3;
	localparam int STATUS_W = 2;

	typedef enum logic [CMD_W-1:0] {
		CMD_PUSH_FRONT = 3'd0,
		CMD_PUSH_BACK  = 3'd1,
		CMD_POP_FRONT  = 3'd2,
		CMD_POP_BACK   = 3'd3,
		CMD_CLEAR      = 3'd4
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	localparam logic [DATA_W-1:0] EMPTY_VALUE = 32'h8000_0001;

	// Per-cycle strobes broadcast to every cell of the chain
	typedef struct packed {
		logic push_front;
		logic push_back;
		logic pop_front;
	} shift_t;

endpackage

### hdl/deq_cell.sv
// One storage cell of the deque chain; cell INDEX holds element INDEX from the front.
// Depends on deq_pkg for the shift strobes and data width.
module deq_cell #(
	parameter int INDEX = 0,
	parameter int CW    = 5
) (
	input  logic                       clk,
	input  deq_pkg::shift_t            shift,
	input  logic [CW-1:0]              count,
	input  logic [deq_pkg::DATA_W-1:0] push_value,
	input  logic [deq_pkg::DATA_W-1:0] left_data,
	input  logic [deq_pkg::DATA_W-1:0] right_data,
	output logic [deq_pkg::DATA_W-1:0] data,
	output logic [deq_pkg::DATA_W-1:0] tap
);

	logic [deq_pkg::DATA_W-1:0] data_q;
	logic                       is_free;
	logic                       is_back;

	assign is_free = (count == CW'(INDEX));
	assign is_back = (count == CW'(INDEX + 1));

	// Front push: left; free cell on back push: push value; front pop: right
	always_ff @(posedge clk) begin
		if (shift.push_front) begin
			data_q <= left_data;
		end else if (shift.push_back && is_free) begin
			data_q <= push_value;
		end else if (shift.pop_front) begin
			data_q <= right_data;
		end
	end

	assign data = data_q;
	assign tap  = is_back ? data_q : '0;

endmodule

### hdl/deq_ctrl.sv
// Command decode, element count and result register of the deque.
// Depends on deq_pkg; drives the shift strobes for the deq_cell chain.
module deq_ctrl #(
	parameter int DEPTH = 16,
	parameter int CW    = 5
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [deq_pkg::CMD_W-1:0]    s_cmd,
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [deq_pkg::DATA_W-1:0]   m_pop_value,
	output logic [deq_pkg::STATUS_W-1:0] m_status,
	output logic [CW-1:0]                m_count,
	input  logic [deq_pkg::DATA_W-1:0]   front_value,
	input  logic [deq_pkg::DATA_W-1:0]   back_value,
	output deq_pkg::shift_t              shift,
	output logic [CW-1:0]                count
);

	logic [CW-1:0]                count_q;
	logic                         m_valid_q;
	logic [deq_pkg::DATA_W-1:0]   pop_value_q;
	deq_pkg::status_t             status_q;
	logic [CW-1:0]                res_count_q;

	logic                         accept;
	logic                         full;
	logic                         empty;
	logic [CW-1:0]                count_d;
	logic [deq_pkg::DATA_W-1:0]   pop_value_d;
	deq_pkg::status_t             status_d;
	deq_pkg::shift_t              shift_d;

	assign s_tready = !m_valid_q || m_tready;
	assign accept   = s_tvalid && s_tready;
	assign full     = (count_q == CW'(DEPTH));
	assign empty    = (count_q == '0);

	always_comb begin
		count_d     = count_q;
		pop_value_d = '0;
		status_d    = deq_pkg::ST_OK;
		shift_d     = '0;
		case (deq_pkg::cmd_t'(s_cmd))
			deq_pkg::CMD_PUSH_FRONT: begin
				if (full) begin
					status_d = deq_pkg::ST_FULL;
				end else begin
					shift_d.push_front = accept;
					count_d            = count_q + CW'(1);
				end
			end
			deq_pkg::CMD_PUSH_BACK: begin
				if (full) begin
					status_d = deq_pkg::ST_FULL;
				end else begin
					shift_d.push_back = accept;
					count_d           = count_q + CW'(1);
				end
			end
			deq_pkg::CMD_POP_FRONT: begin
				if (empty) begin
					status_d    = deq_pkg::ST_EMPTY;
					pop_value_d = deq_pkg::EMPTY_VALUE;
				end else begin
					shift_d.pop_front = accept;
					pop_value_d       = front_value;
					count_d           = count_q - CW'(1);
				end
			end
			deq_pkg::CMD_POP_BACK: begin
				if (empty) begin
					status_d    = deq_pkg::ST_EMPTY;
					pop_value_d = deq_pkg::EMPTY_VALUE;
				end else begin
					pop_value_d = back_value;
					count_d     = count_q - CW'(1);
				end
			end
			deq_pkg::CMD_CLEAR: begin
				count_d = '0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			m_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q <= count_d;
			end
			if (accept) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pop_value_q <= pop_value_d;
			status_q    <= status_d;
			res_count_q <= count_d;
		end
	end

	assign shift       = shift_d;
	assign count       = count_q;
	assign m_tvalid    = m_valid_q;
	assign m_pop_value = pop_value_q;
	assign m_status    = status_q;
	assign m_count     = res_count_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("element count above depth");

	a_strobe_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({shift_d.push_front, shift_d.push_back, shift_d.pop_front}))
		else $error("more than one shift strobe");

	a_empty_marker: assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_q && status_q == deq_pkg::ST_EMPTY |->
		pop_value_q == deq_pkg::EMPTY_VALUE && res_count_q == '0)
		else $error("empty pop result malformed");

	a_result_count: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> res_count_q == count_q)
		else $error("result count differs from held count");

	a_full_refuse: assert property (@(posedge clk) disable iff (!arst_n)
		accept && full && (shift_d.push_front || shift_d.push_back) |-> 1'b0)
		else $error("push accepted into a full deque");

endmodule

### hdl/double_ended_queue.sv
// Double-ended queue of signed 32-bit values built as a chain of storage cells.
// Each result is held in an output register, valid in the cycle after its transfer.
// Throughput: one item per cycle while the result side takes each result;
// every command makes at most one cell-chain shift plus one count-register update.
// Reset clears the element count and output valid; cell contents stay undefined.
// Depends on deq_pkg, deq_cell and deq_ctrl.
module double_ended_queue #(
	parameter int DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   s_tvalid,
	output logic                                   s_tready,
	// [2:0] cmd, [34:3] push_value, [39:35] zero
	input  logic [39:0]                            s_tdata,
	output logic                                   m_tvalid,
	input  logic                                   m_tready,
	// [31:0] pop_value, [33:32] status, then count, then zero fill
	output logic [((34 + $clog2(DEPTH + 1) + 7) / 8) * 8 - 1:0] m_tdata
);

	localparam int CW    = $clog2(DEPTH + 1);
	localparam int RES_W = deq_pkg::DATA_W + deq_pkg::STATUS_W + CW;
	localparam int OUT_W = ((RES_W + 7) / 8) * 8;

	logic [deq_pkg::CMD_W-1:0]    in_cmd;
	logic [deq_pkg::DATA_W-1:0]   in_value;
	logic [deq_pkg::DATA_W-1:0]   res_pop_value;
	logic [deq_pkg::STATUS_W-1:0] res_status;
	logic [CW-1:0]                res_count;

	deq_pkg::shift_t              shift;
	logic [CW-1:0]                count;
	logic [deq_pkg::DATA_W-1:0]   cell_data [DEPTH];
	logic [deq_pkg::DATA_W-1:0]   cell_tap  [DEPTH];
	logic [deq_pkg::DATA_W-1:0]   back_value;

	// Unpack the input transfer
	assign in_cmd   = s_tdata[deq_pkg::CMD_W-1:0];
	assign in_value = s_tdata[deq_pkg::CMD_W +: deq_pkg::DATA_W];

	deq_ctrl #(
		.DEPTH (DEPTH),
		.CW    (CW)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_cmd       (in_cmd),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_pop_value (res_pop_value),
		.m_status    (res_status),
		.m_count     (res_count),
		.front_value (cell_data[0]),
		.back_value  (back_value),
		.shift       (shift),
		.count       (count)
	);

	// Cell 0 holds the front; a front push feeds it the new value,
	// a front pop draws each cell from its right neighbor.
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [deq_pkg::DATA_W-1:0] left_d;
		logic [deq_pkg::DATA_W-1:0] right_d;

		if (i == 0) begin : g_first
			assign left_d = in_value;
		end else begin : g_mid_l
			assign left_d = cell_data[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign right_d = cell_data[i];
		end else begin : g_mid_r
			assign right_d = cell_data[i+1];
		end

		deq_cell #(
			.INDEX (i),
			.CW    (CW)
		) u_cell (
			.clk        (clk),
			.shift      (shift),
			.count      (count),
			.push_value (in_value),
			.left_data  (left_d),
			.right_data (right_d),
			.data       (cell_data[i]),
			.tap        (cell_tap[i])
		);
	end

	// Only the back cell drives its tap; merge the taps
	always_comb begin
		back_value = '0;
		for (int k = 0; k < DEPTH; k++) begin
			back_value = back_value | cell_tap[k];
		end
	end

	// Pack the result transfer, zero fill to whole bytes
	assign m_tdata = OUT_W'({res_count, res_status, res_pop_value});

endmodule

### test/tb_double_ended_queue.sv
`timescale 1ns / 100ps
// Self-checking testbench for double_ended_queue: predicts every result from a shadow deque.
// Depends on deq_pkg and the double_ended_queue RTL.
module tb_double_ended_queue;

	localparam int DEPTH       = 16;
	localparam int COUNT_W     = $clog2(DEPTH + 1);
	localparam int RESULT_W    =
		((deq_pkg::DATA_W + deq_pkg::STATUS_W + COUNT_W + 7) / 8) * 8;
	localparam int CYCLE_LIMIT = 200000;
	localparam int DRAIN_WAIT  = 8;
	localparam int HOLD_CYCLES = 150;
	localparam int IDLE_PCT    = 27;
	localparam int REPORT_MAX  = 10;

	// Codes the block leaves undecoded; they must be ignored
	localparam logic [deq_pkg::CMD_W-1:0] CMD_SPARE_FIRST = 3'd5;
	localparam logic [deq_pkg::CMD_W-1:0] CMD_SPARE_LAST  = 3'd7;

	typedef struct packed {
		logic [deq_pkg::DATA_W-1:0] pop_value;
		deq_pkg::status_t           status;
		logic [COUNT_W-1:0]         count;
	} deq_result_t;

	logic                clk      = 1'b0;
	logic                arst_n   = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	// [2:0] cmd, [34:3] push_value, [39:35] zero
	logic [39:0]         s_tdata  = '0;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	// [31:0] pop_value, [33:32] status, then count, then zero fill
	logic [RESULT_W-1:0] m_tdata;

	// Shadow copy of the deque contents and pointers
	logic [deq_pkg::DATA_W-1:0] shadow_store [DEPTH];
	int                         shadow_front;
	int                         shadow_back;
	int                         shadow_count;
	deq_result_t                pending_results [$];

	int mismatches    = 0;
	int cycle_count   = 0;
	int send_idle_pct = IDLE_PCT;
	int recv_idle_pct = IDLE_PCT;
	int hold_off_left = 0;

	double_ended_queue #(
		.DEPTH(DEPTH)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("[double_ended_queue] ERROR");
			$finish;
		end
	end

	// Work out the result of one item and advance the shadow deque
	function automatic void predict_deque(input logic [deq_pkg::CMD_W-1:0] op,
	                                      input logic [deq_pkg::DATA_W-1:0] value);
		deq_result_t res;
		res.pop_value = '0;
		res.status    = deq_pkg::ST_OK;
		case (op)
			deq_pkg::CMD_PUSH_FRONT: begin
				if (shadow_count >= DEPTH) begin
					res.status = deq_pkg::ST_FULL;
				end else begin
					shadow_front = (shadow_front == 0) ? DEPTH - 1 : shadow_front - 1;
					shadow_store[shadow_front] = value;
					shadow_count++;
				end
			end
			deq_pkg::CMD_PUSH_BACK: begin
				if (shadow_count >= DEPTH) begin
					res.status = deq_pkg::ST_FULL;
				end else begin
					shadow_store[shadow_back] = value;
					shadow_back = (shadow_back == DEPTH - 1) ? 0 : shadow_back + 1;
					shadow_count++;
				end
			end
			deq_pkg::CMD_POP_FRONT: begin
				if (shadow_count == 0) begin
					res.status    = deq_pkg::ST_EMPTY;
					res.pop_value = deq_pkg::EMPTY_VALUE;
				end else begin
					res.pop_value = shadow_store[shadow_front];
					shadow_front = (shadow_front == DEPTH - 1) ? 0 : shadow_front + 1;
					shadow_count--;
				end
			end
			deq_pkg::CMD_POP_BACK: begin
				if (shadow_count == 0) begin
					res.status    = deq_pkg::ST_EMPTY;
					res.pop_value = deq_pkg::EMPTY_VALUE;
				end else begin
					shadow_back = (shadow_back == 0) ? DEPTH - 1 : shadow_back - 1;
					res.pop_value = shadow_store[shadow_back];
					shadow_count--;
				end
			end
			deq_pkg::CMD_CLEAR: begin
				shadow_front = 0;
				shadow_back  = 0;
				shadow_count = 0;
			end
			default: begin
			end
		endcase
		res.count = COUNT_W'(shadow_count);
		pending_results.push_back(res);
	endfunction

	// Offer one item, idling first at random; return once the transfer has happened.
	// Leave s_tvalid high so back-to-back items stream without a bubble.
	task automatic send_item(input logic [deq_pkg::CMD_W-1:0] op,
	                         input logic [deq_pkg::DATA_W-1:0] value);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {5'b0, value, op};
		do @(posedge clk); while (!s_tready);
		predict_deque(op, value);
	endtask

	task automatic flag_mismatch(input string what, input logic [deq_pkg::DATA_W-1:0] want,
	                             input logic [deq_pkg::DATA_W-1:0] got);
		mismatches++;
		if (mismatches <= REPORT_MAX)
			$display("mismatch in %s at %0t: expected %0h, got %0h", what, $time, want, got);
	endtask

	// Receiver: check each result transfer, then pick the next ready value.
	// A pending hold-off forces ready low and is counted down here.
	always @(posedge clk) begin
		deq_result_t want;
		if (m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				flag_mismatch("unexpected result", '0, m_tdata[deq_pkg::DATA_W-1:0]);
			end else begin
				want = pending_results.pop_front();
				if (m_tdata[deq_pkg::DATA_W-1:0] !== want.pop_value)
					flag_mismatch("pop_value", want.pop_value, m_tdata[deq_pkg::DATA_W-1:0]);
				if (m_tdata[deq_pkg::DATA_W +: deq_pkg::STATUS_W] !== want.status)
					flag_mismatch("status", deq_pkg::DATA_W'(want.status),
					              deq_pkg::DATA_W'(m_tdata[deq_pkg::DATA_W +: deq_pkg::STATUS_W]));
				if (m_tdata[deq_pkg::DATA_W + deq_pkg::STATUS_W +: COUNT_W] !== want.count)
					flag_mismatch("count", deq_pkg::DATA_W'(want.count),
					              deq_pkg::DATA_W'(m_tdata[deq_pkg::DATA_W + deq_pkg::STATUS_W +: COUNT_W]));
			end
		end
		if (hold_off_left > 0) begin
			hold_off_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	// Bias toward the extremes now and then
	function automatic logic [deq_pkg::DATA_W-1:0] pick_value();
		case ($urandom_range(0, 9))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
			default: return $urandom;
		endcase
	endfunction

	// Draw a command; push_pct steers the fill level up or down
	function automatic logic [deq_pkg::CMD_W-1:0] pick_command(input int push_pct);
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 1)
			return deq_pkg::CMD_CLEAR;
		if (roll < 3)
			return deq_pkg::CMD_W'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST));
		if ($urandom_range(0, 99) < push_pct)
			return $urandom_range(0, 1) ? deq_pkg::CMD_PUSH_BACK : deq_pkg::CMD_PUSH_FRONT;
		return $urandom_range(0, 1) ? deq_pkg::CMD_POP_BACK : deq_pkg::CMD_POP_FRONT;
	endfunction

	// Empty pops, extreme values from both ends, clear and the ignored codes
	task automatic test_directed_edges();
		send_item(deq_pkg::CMD_POP_FRONT, 32'h0);
		send_item(deq_pkg::CMD_POP_BACK, 32'hFFFF_FFFF);
		send_item(deq_pkg::CMD_PUSH_FRONT, 32'h8000_0000);   // front index wraps below zero
		send_item(deq_pkg::CMD_PUSH_BACK, 32'h7FFF_FFFF);
		send_item(deq_pkg::CMD_PUSH_FRONT, 32'hFFFF_FFFF);
		send_item(deq_pkg::CMD_PUSH_BACK, 32'h0);
		send_item(deq_pkg::CMD_POP_BACK, $urandom);
		send_item(deq_pkg::CMD_POP_FRONT, $urandom);
		send_item(deq_pkg::CMD_POP_FRONT, $urandom);
		send_item(deq_pkg::CMD_POP_BACK, $urandom);
		send_item(deq_pkg::CMD_POP_BACK, $urandom);         // drained again
		send_item(deq_pkg::CMD_PUSH_BACK, 32'h1234_5678);
		send_item(deq_pkg::CMD_CLEAR, 32'hFFFF_FFFF);
		send_item(deq_pkg::CMD_POP_FRONT, $urandom);        // nothing readable after clear
		for (logic [deq_pkg::CMD_W:0] op = CMD_SPARE_FIRST; op <= CMD_SPARE_LAST; op++)
			send_item(op[deq_pkg::CMD_W-1:0], $urandom);
		send_item(deq_pkg::CMD_PUSH_FRONT, 32'hA5A5_A5A5);
		send_item(CMD_SPARE_LAST, 32'h5A5A_5A5A);  // count must stay at one
		send_item(deq_pkg::CMD_POP_FRONT, $urandom);
		send_item(deq_pkg::CMD_CLEAR, $urandom);
	endtask

	// Hold the result side off while pushes keep coming: the block stalls its input,
	// the deque fills up and the late pushes are refused; then drain past empty.
	task automatic test_backpressure_fill();
		send_idle_pct = 0;
		hold_off_left = HOLD_CYCLES;
		repeat (DEPTH + 4)
			send_item($urandom_range(0, 1) ? deq_pkg::CMD_PUSH_BACK : deq_pkg::CMD_PUSH_FRONT,
			          pick_value());
		repeat (DEPTH + 2)
			send_item($urandom_range(0, 1) ? deq_pkg::CMD_POP_BACK : deq_pkg::CMD_POP_FRONT,
			          $urandom);
		send_idle_pct = IDLE_PCT;
	endtask

	// Random traffic in segments whose push bias sweeps the fill level
	task automatic test_random_traffic(input int num_items);
		int push_pct;
		push_pct = 50;
		for (int i = 0; i < num_items; i++) begin
			if (i % 40 == 0) begin
				case ($urandom_range(0, 2))
					0: push_pct = 20;
					1: push_pct = 50;
					default: push_pct = 80;
				endcase
			end
			send_item(pick_command(push_pct), pick_value());
		end
	endtask

	// Same traffic with neither side idling
	task automatic test_streaming_no_gaps(input int num_items);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random_traffic(num_items);
		send_idle_pct = IDLE_PCT;
		recv_idle_pct = IDLE_PCT;
	endtask

	initial begin
		shadow_front = 0;
		shadow_back  = 0;
		shadow_count = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_edges();
		test_backpressure_fill();
		test_random_traffic(550);
		test_streaming_no_gaps(250);
		test_random_traffic(300);

		// Drop valid, wait out the outstanding results, then catch any stray ones
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		if (mismatches == 0)
			$display("[double_ended_queue] OK");
		else
			$display("[double_ended_queue] ERROR");
		$finish;
	end

endmodule
